// ===== src/hrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, codes and method tables for the HTTP request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam int MAX_REQ_BYTES_DEF = 65535;

    localparam int NUM_METHODS = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_URL_CAP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_CAP = 1'd1;

    localparam logic [15:0] URL_CAP_RST  = 16'd256;
    localparam logic [15:0] BODY_CAP_RST = 16'd1024;

    localparam logic [2:0] METH_GET     = 3'd0;
    localparam logic [2:0] METH_POST    = 3'd1;
    localparam logic [2:0] METH_PUT     = 3'd2;
    localparam logic [2:0] METH_DELETE  = 3'd3;
    localparam logic [2:0] METH_PATCH   = 3'd4;
    localparam logic [2:0] METH_HEAD    = 3'd5;
    localparam logic [2:0] METH_OPTIONS = 3'd6;
    localparam logic [2:0] METH_UNKNOWN = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PARSE     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef struct packed {
        logic [15:0] url_cap;
        logic [15:0] body_cap;
    } cfg_t;

    typedef struct packed {
        logic [15:0] body_length;
        logic [15:0] body_offset;
        logic [15:0] url_length;
        logic [15:0] url_offset;
        logic [1:0]  status;
        logic [2:0]  method_code;
    } result_t;

    // method text, first character in the lowest byte
    function automatic logic [63:0] method_text(input logic [2:0] m);
        logic [63:0] t;
        case (m)
            METH_GET:     t = {40'h0, "TEG"};
            METH_POST:    t = {32'h0, "TSOP"};
            METH_PUT:     t = {40'h0, "TUP"};
            METH_DELETE:  t = {16'h0, "ETELED"};
            METH_PATCH:   t = {24'h0, "HCTAP"};
            METH_HEAD:    t = {32'h0, "DAEH"};
            METH_OPTIONS: t = {8'h0, "SNOITPO"};
            default:      t = 64'h0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] method_len(input logic [2:0] m);
        logic [2:0] n;
        case (m)
            METH_GET:     n = 3'd3;
            METH_POST:    n = 3'd4;
            METH_PUT:     n = 3'd3;
            METH_DELETE:  n = 3'd6;
            METH_PATCH:   n = 3'd5;
            METH_HEAD:    n = 3'd4;
            METH_OPTIONS: n = 3'd7;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== src/hrlp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hrlp_cfg_regs
// Capacity registers written through the configuration channel.
// ----------------------------------------------------------------------------
module hrlp_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hrlp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    output hrlp_pkg::cfg_t                 cfg_o
);
    import hrlp_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg_o     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.url_cap  <= URL_CAP_RST;
            cfg_reg.body_cap <= BODY_CAP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_URL_CAP:  cfg_reg.url_cap  <= cfg_data;
                REG_BODY_CAP: cfg_reg.body_cap <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== src/hrlp_tracker.sv =====
// ----------------------------------------------------------------------------
// hrlp_tracker
// Per-request state: position, method matcher, url phases, crlf tracker,
// and the result of a request on its last byte.
// ----------------------------------------------------------------------------
module hrlp_tracker #(
    parameter int MAX_REQUEST_BYTES = hrlp_pkg::MAX_REQ_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_i,
    input  logic [7:0]        byte_i,
    input  logic              last_i,
    input  hrlp_pkg::cfg_t    cfg_i,
    output hrlp_pkg::result_t result_o
);
    import hrlp_pkg::*;

    localparam int POS_W = $clog2(MAX_REQUEST_BYTES + 2);
    localparam int CMP_W = (POS_W > 16) ? POS_W : 16;

    typedef enum logic [2:0] {
        PH_SEEK_SPACE,
        PH_EXPECT_SLASH,
        PH_IN_URL,
        PH_EXPECT_H,
        PH_DONE,
        PH_FAILED
    } phase_t;

    logic [POS_W-1:0]       pos_reg, pos_next, pos_inc;
    logic [NUM_METHODS-1:0] cand_reg, cand_next, hit;
    logic [2:0]             matched_reg, matched_next;
    phase_t                 phase_reg, phase_next;
    logic [15:0]            ustart_reg, ustart_next;
    logic [15:0]            uend_reg, uend_next;
    logic [1:0]             crlf_reg, crlf_next;
    logic [15:0]            bstart_reg, bstart_next;
    logic                   bseen_reg, bseen_next;

    logic                   pos_lt7;
    logic [2:0]             p3;
    logic [15:0]            url_len;
    logic [CMP_W-1:0]       tot_c, bs_c, body_bytes;

    assign pos_inc = pos_reg + POS_W'(1);
    assign pos_lt7 = pos_reg < POS_W'(7);
    assign p3      = pos_reg[2:0];

    // method prefix matcher
    always_comb begin
        logic [2:0]  len;
        logic [63:0] txt;
        logic [7:0]  ch;
        cand_next = cand_reg;
        hit       = '0;
        for (int i = 0; i < NUM_METHODS; i++) begin
            len = method_len(3'(i));
            txt = method_text(3'(i));
            ch  = txt[{p3, 3'b000} +: 8];
            if (cand_reg[i] && pos_lt7 && (p3 < len)) begin
                if (byte_i != ch) begin
                    cand_next[i] = 1'b0;
                end else if (({1'b0, p3} + 4'd1) == {1'b0, len}) begin
                    hit[i] = 1'b1;
                end
            end
        end
        matched_next = matched_reg;
        if (matched_reg == METH_UNKNOWN) begin
            for (int i = NUM_METHODS - 1; i >= 0; i--) begin
                if (hit[i]) begin
                    matched_next = 3'(i);
                end
            end
        end
    end

    // url phases
    always_comb begin
        phase_next  = phase_reg;
        ustart_next = ustart_reg;
        uend_next   = uend_reg;
        case (phase_reg)
            PH_SEEK_SPACE: begin
                if (byte_i == CH_SPACE) begin
                    ustart_next = 16'(pos_inc);
                    phase_next  = PH_EXPECT_SLASH;
                end
            end
            PH_EXPECT_SLASH: begin
                phase_next = (byte_i == CH_SLASH) ? PH_IN_URL : PH_FAILED;
            end
            PH_IN_URL: begin
                if (byte_i == CH_SPACE) begin
                    uend_next  = 16'(pos_reg);
                    phase_next = PH_EXPECT_H;
                end
            end
            PH_EXPECT_H: begin
                phase_next = (byte_i == CH_H) ? PH_DONE : PH_FAILED;
            end
            default: ;
        endcase
    end

    // cr lf cr lf tracker
    always_comb begin
        crlf_next   = 2'd0;
        bstart_next = bstart_reg;
        bseen_next  = bseen_reg;
        if (byte_i == CH_CR) begin
            crlf_next = (crlf_reg == 2'd2) ? 2'd3 : 2'd1;
        end else if (byte_i == CH_LF) begin
            if (crlf_reg == 2'd1) begin
                crlf_next = 2'd2;
            end else if (crlf_reg == 2'd3) begin
                bstart_next = 16'(pos_inc);
                bseen_next  = 1'b1;
                crlf_next   = 2'd2;
            end
        end
    end

    assign pos_next = (pos_reg <= POS_W'(MAX_REQUEST_BYTES)) ? pos_inc : pos_reg;

    // result from the updated state
    assign url_len    = uend_next - ustart_next;
    assign tot_c      = CMP_W'(pos_next);
    assign bs_c       = CMP_W'(bstart_next);
    assign body_bytes = (tot_c >= bs_c) ? (tot_c - bs_c) : '0;

    always_comb begin
        result_o             = '0;
        result_o.method_code = matched_next;
        if (pos_next > POS_W'(MAX_REQUEST_BYTES)) begin
            result_o.status = ST_TOO_LONG;
        end else if (phase_next != PH_DONE) begin
            result_o.status = ST_PARSE;
        end else if (url_len >= cfg_i.url_cap) begin
            result_o.status = ST_OVERFLOW;
        end else begin
            result_o.url_offset = ustart_next;
            result_o.url_length = url_len;
            if (!bseen_next) begin
                result_o.status = ST_PARSE;
            end else if (body_bytes >= CMP_W'(cfg_i.body_cap)) begin
                result_o.status = ST_OVERFLOW;
            end else begin
                result_o.status      = ST_OK;
                result_o.body_offset = bstart_next;
                result_o.body_length = 16'(body_bytes);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_i && last_i)) begin
            pos_reg     <= '0;
            cand_reg    <= '1;
            matched_reg <= METH_UNKNOWN;
            phase_reg   <= PH_SEEK_SPACE;
            ustart_reg  <= '0;
            uend_reg    <= '0;
            crlf_reg    <= '0;
            bstart_reg  <= '0;
            bseen_reg   <= 1'b0;
        end else if (step_i) begin
            pos_reg     <= pos_next;
            cand_reg    <= cand_next;
            matched_reg <= matched_next;
            phase_reg   <= phase_next;
            ustart_reg  <= ustart_next;
            uend_reg    <= uend_next;
            crlf_reg    <= crlf_next;
            bstart_reg  <= bstart_next;
            bseen_reg   <= bseen_next;
        end
    end

endmodule

// ===== src/http_request_line_parser_top.sv =====
// ----------------------------------------------------------------------------
// http_request_line_parser_top
// Streaming HTTP request line parser: one request byte per beat, one result
// beat on the last byte of each request.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+---------------------------------
//   s_       | in  | s_tvalid/s_tready  | s_tdata byte, s_tlast last byte
//   m_       | out | m_tvalid/m_tready  | m_tdata result fields
//   cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one byte per cycle sustained except when a last byte finds the output full;
// bytes enter the input register, and a last byte's result is registered into the
// output register as it advances; the state and result logic sets the pace
// reset clears all request state and loads the default capacities
// a full output register stalls only on a last byte; other bytes keep flowing
// ----------------------------------------------------------------------------
module http_request_line_parser_top #(
    parameter int MAX_REQUEST_BYTES = hrlp_pkg::MAX_REQ_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // byte_value
    input  logic                           s_tlast,   // is_last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // method_code[2:0], status[4:3], url_offset[20:5], url_length[36:21],
    // body_offset[52:37], body_length[68:53], zero[71:69]
    output logic [71:0]                    m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hrlp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import hrlp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    result_t    result;
    cfg_t       cfg;
    logic       advance;

    hrlp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    hrlp_tracker #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_i   (advance),
        .byte_i   (in_byte_reg),
        .last_i   (in_last_reg),
        .cfg_i    (cfg),
        .result_o (result)
    );

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== sim/tb_http_request_line_parser_top.sv =====
// ----------------------------------------------------------------------------
// tb_http_request_line_parser_top
// Self-checking bench for the request line parser. Requests are streamed one
// byte per beat under random source and sink gaps; a behavioral parser in the
// bench predicts each result beat and the monitor compares it field by field.
// Capacities are rewritten between phases, from one up to the largest value.
// ----------------------------------------------------------------------------
module tb_http_request_line_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hrlp_pkg::*;

    localparam int REQ_MAX = MAX_REQ_BYTES_DEF;

    typedef enum logic [2:0] {
        SEEK_SP, WANT_SLASH, IN_PATH, WANT_H, PATH_DONE, PATH_BAD
    } url_step_e;

    typedef enum logic [1:0] {NO_EOL, GOT_CR, GOT_CRLF, GOT_CRLFCR} eol_e;

    typedef struct packed {
        logic [7:0] chr;
        logic       is_end;
    } req_beat_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [71:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_URL_CAP;
    logic [15:0]          cfg_data  = 16'h0;

    // bench side copy of the parser
    logic [15:0] url_cap  = URL_CAP_RST;
    logic [15:0] body_cap = BODY_CAP_RST;
    logic [16:0] pos_cnt;
    logic [6:0]  meth_cand;
    logic [2:0]  meth_hit;
    url_step_e   url_step;
    logic [15:0] url_beg, url_end, body_beg;
    eol_e        eol_st;
    logic        body_found;

    result_t     parse_results_q[$];
    req_beat_t   beat_q[$];
    logic [7:0]  req_buf[$];
    req_beat_t   nxt_beat;

    int n_sent = 0;
    int n_acc  = 0;
    int n_err  = 0;
    int src_gap = 0;
    int snk_gap = 0;
    int hold_left = 0;
    int hold_seen = 0;
    int hold_reqs = 0;
    logic src_idle_en = 1'b1;
    logic snk_idle_en = 1'b1;

    logic [15:0] url_cap_set [5]  = '{16'd1, 16'd4, 16'd9, 16'd20, 16'd256};
    logic [15:0] body_cap_set [5] = '{16'd1, 16'd3, 16'd16, 16'd6, 16'd1024};

    http_request_line_parser_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic string word_text(input int m);
        string w;
        case (m)
            int'(METH_GET):     w = "GET";
            int'(METH_POST):    w = "POST";
            int'(METH_PUT):     w = "PUT";
            int'(METH_DELETE):  w = "DELETE";
            int'(METH_PATCH):   w = "PATCH";
            int'(METH_HEAD):    w = "HEAD";
            default:            w = "OPTIONS";
        endcase
        return w;
    endfunction

    function automatic int pick_gap(input logic en);
        int r;
        r = int'($urandom_range(0, 99));
        if (!en || r < 65)
            return 0;
        if (r < 93)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    task automatic clear_track();
        pos_cnt    = '0;
        meth_cand  = '1;
        meth_hit   = METH_UNKNOWN;
        url_step   = SEEK_SP;
        url_beg    = '0;
        url_end    = '0;
        eol_st     = NO_EOL;
        body_beg   = '0;
        body_found = 1'b0;
    endtask

    task automatic track_byte(input logic [7:0] c, input logic is_end);
        int p, i, total, ulen, blen;
        string w;
        logic [15:0] d16;
        result_t r;
        p = int'(pos_cnt);
        if (p < 7) begin
            for (i = 0; i < 7; i++) begin
                w = word_text(i);
                if (meth_cand[i] && p < w.len()) begin
                    if (c != w.getc(p))
                        meth_cand[i] = 1'b0;
                    else if (p + 1 == w.len() && meth_hit == METH_UNKNOWN)
                        meth_hit = 3'(i);
                end
            end
        end
        case (url_step)
            SEEK_SP: begin
                if (c == CH_SPACE) begin
                    url_beg  = 16'(p + 1);
                    url_step = WANT_SLASH;
                end
            end
            WANT_SLASH: url_step = (c == CH_SLASH) ? IN_PATH : PATH_BAD;
            IN_PATH: begin
                if (c == CH_SPACE) begin
                    url_end  = 16'(p);
                    url_step = WANT_H;
                end
            end
            WANT_H: url_step = (c == CH_H) ? PATH_DONE : PATH_BAD;
            default: ;
        endcase
        if (c == CH_CR) begin
            eol_st = (eol_st == GOT_CRLF) ? GOT_CRLFCR : GOT_CR;
        end else if (c == CH_LF) begin
            if (eol_st == GOT_CR) begin
                eol_st = GOT_CRLF;
            end else if (eol_st == GOT_CRLFCR) begin
                body_beg   = 16'(p + 1);
                body_found = 1'b1;
                eol_st     = GOT_CRLF;
            end else begin
                eol_st = NO_EOL;
            end
        end else begin
            eol_st = NO_EOL;
        end
        if (p <= REQ_MAX)
            pos_cnt = pos_cnt + 17'd1;
        if (is_end) begin
            total = int'(pos_cnt);
            r = '0;
            r.method_code = meth_hit;
            if (total > REQ_MAX) begin
                r.status = ST_TOO_LONG;
            end else if (url_step != PATH_DONE) begin
                r.status = ST_PARSE;
            end else begin
                d16  = url_end - url_beg;
                ulen = int'(d16);
                if (ulen >= int'(url_cap)) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    r.url_offset = url_beg;
                    r.url_length = d16;
                    if (!body_found) begin
                        r.status = ST_PARSE;
                    end else begin
                        blen = (total >= int'(body_beg)) ? total - int'(body_beg) : 0;
                        if (blen >= int'(body_cap)) begin
                            r.status = ST_OVERFLOW;
                        end else begin
                            r.body_offset = body_beg;
                            r.body_length = 16'(blen);
                        end
                    end
                end
            end
            parse_results_q.push_back(r);
            clear_track();
        end
    endtask

    task automatic field_err(input string f, input logic [15:0] w, input logic [15:0] g);
        n_err++;
        $display("%0t mismatch %s: expected %0d, got %0d", $time, f, w, g);
    endtask

    task automatic check_result(input logic [71:0] d);
        result_t want, got;
        got = d[68:0];
        if (parse_results_q.size() == 0) begin
            n_err++;
            $display("%0t unexpected result beat: expected none, got %h", $time, d);
        end else begin
            want = parse_results_q.pop_front();
            if (got.method_code !== want.method_code)
                field_err("method_code", 16'(want.method_code), 16'(got.method_code));
            if (got.status !== want.status)
                field_err("status", 16'(want.status), 16'(got.status));
            if (got.url_offset !== want.url_offset)
                field_err("url_offset", want.url_offset, got.url_offset);
            if (got.url_length !== want.url_length)
                field_err("url_length", want.url_length, got.url_length);
            if (got.body_offset !== want.body_offset)
                field_err("body_offset", want.body_offset, got.body_offset);
            if (got.body_length !== want.body_length)
                field_err("body_length", want.body_length, got.body_length);
            if (d[71:69] !== 3'b000)
                field_err("pad", 16'd0, 16'(d[71:69]));
        end
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_byte(s_tdata, s_tlast);
                n_acc++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    nxt_beat = beat_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt_beat.chr;
                    s_tlast  <= nxt_beat.is_end;
                    src_gap = pick_gap(src_idle_en);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_gap = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                snk_gap = pick_gap(snk_idle_en);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = 400;
                m_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        req_buf.push_back(b);
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            req_buf.push_back(s.getc(i));
    endtask

    task automatic put_crlf();
        req_buf.push_back(CH_CR);
        req_buf.push_back(CH_LF);
    endtask

    task automatic put_visible(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0)
                put_byte(8'($urandom_range(128, 255)));
            else
                put_byte(8'($urandom_range(33, 126)));
        end
    endtask

    task automatic send_req();
        int i, n;
        req_beat_t b;
        n = req_buf.size();
        for (i = 0; i < n; i++) begin
            b.chr    = req_buf[i];
            b.is_end = (i == n - 1);
            beat_q.push_back(b);
        end
        n_sent += n;
        req_buf.delete();
    endtask

    task automatic send_text(input string s);
        put_text(s);
        send_req();
    endtask

    // request line, empty header block, optional body text
    task automatic send_simple(input string line, input string body);
        put_text(line);
        put_crlf();
        put_crlf();
        put_text(body);
        send_req();
    endtask

    task automatic gen_request();
        int kind, k, n, i;
        string w;
        kind = int'($urandom_range(0, 99));
        if (kind < 6) begin
            n = int'($urandom_range(1, 24));
            for (i = 0; i < n; i++)
                put_byte(8'($urandom_range(1, 255)));
        end else begin
            k = int'($urandom_range(0, 9));
            if (k < 7) begin
                put_text(word_text(k));
            end else if (k == 7) begin
                w = word_text(int'($urandom_range(0, 6)));
                n = int'($urandom_range(1, w.len() - 1));
                for (i = 0; i < n; i++)
                    put_byte(w.getc(i));
            end else begin
                n = int'($urandom_range(1, 7));
                for (i = 0; i < n; i++)
                    put_byte(8'($urandom_range(65, 90)));
            end
            if (kind >= 10) begin
                put_byte(CH_SPACE);
                if (kind < 14)
                    put_byte(8'($urandom_range(48, 122)));
                else
                    put_byte(CH_SLASH);
                if (url_cap <= 16'd64 && $urandom_range(0, 3) == 0)
                    n = int'(url_cap) - 2 + int'($urandom_range(0, 1));
                else
                    n = int'($urandom_range(0, 10));
                put_visible((n < 0) ? 0 : n);
                if (kind >= 18) begin
                    put_byte(CH_SPACE);
                    if (kind < 22)
                        put_byte(8'($urandom_range(97, 122)));
                    else
                        put_text("HTTP/1.1");
                    n = int'($urandom_range(0, 2));
                    for (i = 0; i < n; i++) begin
                        put_crlf();
                        put_text("X-");
                        put_visible(int'($urandom_range(1, 6)));
                    end
                    if (kind < 28) begin
                        if ($urandom_range(0, 1) == 1)
                            put_crlf();
                    end else begin
                        put_crlf();
                        put_crlf();
                        if (body_cap <= 16'd64 && $urandom_range(0, 3) == 0)
                            n = int'(body_cap) - 1 + int'($urandom_range(0, 1));
                        else
                            n = int'($urandom_range(0, 12));
                        for (i = 0; i < n; i++) begin
                            if (i == n / 2 && $urandom_range(0, 4) == 0) begin
                                put_crlf();
                                put_crlf();
                            end
                            put_byte(8'($urandom_range(1, 255)));
                        end
                    end
                end
            end
        end
        send_req();
    endtask

    task automatic wait_idle();
        while (n_acc != n_sent || parse_results_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_cap(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (idx == REG_URL_CAP)
            url_cap = val;
        else
            body_cap = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int budget, input logic mid_pause);
        int start;
        logic paused;
        start  = n_sent;
        paused = 1'b0;
        while (n_sent - start < budget) begin
            gen_request();
            if (mid_pause && !paused && n_sent - start >= budget / 2) begin
                paused = 1'b1;
                wait_idle();
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("[http_request_line_parser_top] ERROR");
        $finish;
    end

    initial begin
        int ph, i;
        clear_track();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed requests at reset capacities
        send_simple("GET / HTTP", "");
        put_text("POST /a HTTP/1.1");
        put_crlf();
        put_text("Host: x");
        put_crlf();
        put_crlf();
        put_text("ab");
        send_req();
        put_text("PUT /p H");
        put_crlf();
        put_crlf();
        put_byte(8'hff);
        put_byte(8'h01);
        put_byte(8'h80);
        put_byte(8'h7f);
        send_req();
        send_simple("DELETE /d H", "");
        send_simple("PATCH /q H", "z");
        send_simple("HEAD /h H", "");
        send_simple("OPTIONS /o H", "");
        send_simple("BREW / H", "");
        send_simple("GETS / H", "x");
        send_text("GE");
        send_text("GET ");
        send_text("GET /x ");
        send_simple("GET x H", "");
        send_simple("GET /x Y", "");
        put_text("GET /x HTTP");
        put_crlf();
        put_text("a");
        put_crlf();
        send_req();
        // overlapping blank lines
        put_text("GET /x H");
        put_crlf();
        put_crlf();
        put_crlf();
        put_text("b");
        send_req();
        // second blank line inside the body wins
        put_text("GET /x H");
        put_crlf();
        put_crlf();
        put_text("c");
        put_crlf();
        put_crlf();
        put_text("dd");
        send_req();
        put_text("GET / H");
        put_byte(CH_CR);
        put_crlf();
        put_crlf();
        send_req();
        send_text("P");
        put_byte(8'hff);
        send_req();
        // url one below and at the default capacity
        put_text("GET /");
        for (i = 0; i < 254; i++)
            put_byte(8'(97 + i % 26));
        put_text(" H");
        put_crlf();
        put_crlf();
        send_req();
        put_text("GET /");
        for (i = 0; i < 255; i++)
            put_byte(8'(97 + i % 26));
        put_text(" H");
        put_crlf();
        put_crlf();
        send_req();
        wait_idle();

        // sink holds off while short requests keep coming
        src_idle_en <= 1'b0;
        snk_idle_en <= 1'b0;
        hold_reqs <= hold_reqs + 1;
        repeat (3) @(posedge aclk);
        for (i = 0; i < 24; i++) begin
            if (i % 3 == 0)
                send_simple("GET / H", "");
            else
                send_text("G");
        end
        wait_idle();

        // largest capacities
        write_cap(REG_URL_CAP, 16'hffff);
        write_cap(REG_BODY_CAP, 16'hffff);
        run_random(100, 1'b1);
        wait_idle();

        for (ph = 0; ph < 5; ph++) begin
            write_cap(REG_URL_CAP, url_cap_set[ph]);
            write_cap(REG_BODY_CAP, body_cap_set[ph]);
            src_idle_en <= (ph != 2);
            snk_idle_en <= (ph != 3);
            run_random(60, 1'b0);
            wait_idle();
        end

        if (n_err == 0)
            $display("[http_request_line_parser_top] OK");
        else
            $display("[http_request_line_parser_top] ERROR");
        $finish;
    end

endmodule
